FILE: rtl/ddw_pkg.sv
// ----------------------------------------------------------------------------
// ddw_pkg: shared types and constants for the wheel PWM regulator
// Field widths, register indexes, reset values, and the sizes of the shared
// multiplier.
// ----------------------------------------------------------------------------
package ddw_pkg;

  localparam int ACC_FRAC_BITS_DEF = 8;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int SPEED_W    = 16;
  localparam int PWM_W      = 11;
  localparam int LIMIT_W    = 10;

  // Shared multiplier: signed operand by zero-extended 16-bit register
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // 0.01 in Q4.12 and the forced turn-in-place speed 0.1 in Q4.12
  localparam logic signed [SPEED_W:0]   LIN_THRESH   = 17'sd41;
  localparam logic signed [SPEED_W:0]   ANG_THRESH   = 17'sd41;
  localparam logic signed [SPEED_W-1:0] MIN_TURN_LIN = 16'sd410;

  typedef enum logic {
    ACT_COMMAND  = 1'b0,
    ACT_FEEDBACK = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_TRACK = 8'd0,
    REG_RPM_PER_MPS = 8'd1,
    REG_GAIN_P     = 8'd2,
    REG_PWM_LIMIT  = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        half_track_width;
    logic [15:0]        rpm_per_mps;
    logic [15:0]        gain_p;
    logic [LIMIT_W-1:0] pwm_limit;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    half_track_width: 16'd17367,
    rpm_per_mps:      16'd28759,
    gain_p:           16'd410,
    pwm_limit:        10'd300
  };

endpackage

FILE: rtl/ddw_if.sv
// ----------------------------------------------------------------------------
// ddw_if: request, result and configuration channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ddw_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [ddw_pkg::SPEED_W-1:0]   fwd_speed;
  logic signed [ddw_pkg::SPEED_W-1:0]   yaw_rate;
  logic signed [ddw_pkg::SPEED_W-1:0]   speed_left;
  logic signed [ddw_pkg::SPEED_W-1:0]   speed_right;

  modport source (output valid, action, fwd_speed, yaw_rate,
                  speed_left, speed_right, input ready);
  modport sink (input valid, action, fwd_speed, yaw_rate,
                speed_left, speed_right, output ready);
endinterface

interface ddw_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddw_pkg::PWM_W-1:0]   duty_left;
  logic signed [ddw_pkg::PWM_W-1:0]   duty_right;

  modport source (output valid, duty_left, duty_right, input ready);
  modport sink (input valid, duty_left, duty_right, output ready);
endinterface

interface ddw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ddw_pkg::CFG_IDX_W-1:0]     index;
  logic [ddw_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ddw_cfg.sv
// ----------------------------------------------------------------------------
// ddw_cfg: configuration register file
// Holds track width, RPM scale, gain and PWM limit; writes to unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module ddw_cfg (
  input  logic               clk,
  input  logic               rst,
  ddw_cfg_if.sink            cfg,
  output ddw_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= ddw_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ddw_pkg::REG_HALF_TRACK:  regs.half_track_width <= cfg.data;
        ddw_pkg::REG_RPM_PER_MPS: regs.rpm_per_mps <= cfg.data;
        ddw_pkg::REG_GAIN_P:      regs.gain_p <= cfg.data;
        ddw_pkg::REG_PWM_LIMIT:   regs.pwm_limit <= cfg.data[ddw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/ddw_mul.sv
// ----------------------------------------------------------------------------
// ddw_mul: shared signed multiplier
// One product per cycle, registered; the sequencer reads it in the following cycle.
// ----------------------------------------------------------------------------
module ddw_mul (
  input  logic                                clk,
  input  logic signed [ddw_pkg::MUL_A_W-1:0]  a,
  input  logic signed [ddw_pkg::MUL_B_W-1:0]  b,
  output logic signed [ddw_pkg::MUL_P_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/diff_drive_wheel_pwm_regulator.sv
// ----------------------------------------------------------------------------
// diff_drive_wheel_pwm_regulator: proportional wheel speed regulator
// Velocity commands set wheel RPM targets and step the drive accumulators;
// feedback items update the drive accumulators and return clamped PWM commands.
// ----------------------------------------------------------------------------
// A command request (action 0) runs S_TURN and S_TURNQ, then S_EX to S_ACC for
// each wheel, and gives no result; a feedback request (action 1) runs S_FML to
// S_FOUT and leaves one PWM result in the output register, where it waits until
// taken. Both use a single registered multiplier that a small sequencer reuses
// for the turn term, the wheel RPM and the gain products, one wheel after the
// other. The next request is taken while a result still waits, though a
// feedback request stalls in S_FOUT until the previous result has gone.
// Configuration may only be written while the block is idle.
module diff_drive_wheel_pwm_regulator #(
  parameter int ACC_FRAC_BITS = ddw_pkg::ACC_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ddw_item_if.sink    item,
  ddw_result_if.source result,
  ddw_cfg_if.sink     cfg
);

  localparam int PWM_W     = ddw_pkg::PWM_W;
  localparam int PSUM_W    = 55;
  localparam int INC_SHIFT = 32 - ACC_FRAC_BITS;
  localparam int INC_W     = PSUM_W - INC_SHIFT;
  localparam int SUM_W     = ((INC_W > 32) ? INC_W : 32) + 2;
  localparam int FB_SHL    = (ACC_FRAC_BITS >= 12) ? ACC_FRAC_BITS - 12 : 0;
  localparam int FB_SHR    = (ACC_FRAC_BITS >= 12) ? 0 : 12 - ACC_FRAC_BITS;
  localparam int TR_W      = 33 - ACC_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] ACC_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_TURN, S_TURNQ, S_EX, S_HI, S_LO, S_SUM, S_ACC,
    S_FML, S_FAL, S_FAR, S_FTR, S_FOUT
  } state_t;

  ddw_pkg::cfg_regs_t regs;

  state_t state;
  logic   side;

  logic signed [15:0]       cmd_linear;
  logic signed [15:0]       cmd_angular;
  logic signed [15:0]       target_rpm_left;
  logic signed [15:0]       target_rpm_right;
  logic signed [31:0]       drive_left_acc;
  logic signed [31:0]       drive_right_acc;
  logic signed [PWM_W-1:0]  held_out_left;
  logic signed [PWM_W-1:0]  held_out_right;

  logic signed [15:0]       sl_r;
  logic signed [15:0]       sr_r;
  logic signed [15:0]       turn_r;
  logic [19:0]              lo_r;
  logic signed [33:0]       phi_r;
  logic signed [INC_W-1:0]  inc_r;
  logic signed [TR_W-1:0]   il_r;
  logic signed [TR_W-1:0]   ir_r;
  logic                     out_valid;
  logic signed [PWM_W-1:0]  out_left;
  logic signed [PWM_W-1:0]  out_right;
  logic                     emit;

  logic signed [ddw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ddw_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ddw_pkg::MUL_P_W-1:0] mult_q;

  ddw_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ddw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mult_q)
  );

  function automatic logic signed [TR_W-1:0] trunc_acc(input logic signed [31:0] a);
    logic signed [31:0] q;
    logic               rnd;
    q   = a >>> ACC_FRAC_BITS;
    rnd = a[31] && (a[ACC_FRAC_BITS-1:0] != '0);
    return TR_W'(q) + $signed({{(TR_W-1){1'b0}}, rnd});
  endfunction

  function automatic logic signed [PWM_W-1:0] clamp_pwm(
    input logic signed [TR_W-1:0]         v,
    input logic [ddw_pkg::LIMIT_W-1:0]    lim
  );
    logic signed [TR_W-1:0]  lim_s;
    logic signed [PWM_W-1:0] r;
    lim_s = $signed(TR_W'(lim));
    if (v > lim_s) begin
      r = $signed({1'b0, lim});
    end else if (v < -lim_s) begin
      r = -$signed({1'b0, lim});
    end else begin
      r = v[PWM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] s);
    logic signed [31:0] r;
    if (s > ACC_MAX) begin
      r = ACC_MAX[31:0];
    end else if (s < ACC_MIN) begin
      r = ACC_MIN[31:0];
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Command forcing: turn in place gets a minimum forward speed
  logic signed [16:0] abs_lin;
  logic signed [16:0] abs_ang;
  logic signed [15:0] lin_forced;

  always_comb begin
    abs_lin = item.fwd_speed[15] ? -17'(item.fwd_speed)
                                 : 17'(item.fwd_speed);
    abs_ang = item.yaw_rate[15] ? -17'(item.yaw_rate)
                                : 17'(item.yaw_rate);
    lin_forced = item.fwd_speed;
    if (abs_lin < ddw_pkg::LIN_THRESH && abs_ang >= ddw_pkg::ANG_THRESH) begin
      lin_forced = (item.yaw_rate > 0) ? ddw_pkg::MIN_TURN_LIN
                                       : -ddw_pkg::MIN_TURN_LIN;
    end
  end

  // Datapath around the shared multiplier
  logic signed [33:0]        exact;
  logic signed [16:0]        ex_hi;
  logic signed [15:0]        tgt_cur;
  logic signed [16:0]        hi_diff;
  logic                      ex_rnd;
  logic signed [15:0]        tgt_new;
  logic signed [16:0]        v_left;
  logic signed [16:0]        v_right;
  logic signed [16:0]        err_l;
  logic signed [16:0]        err_r;
  logic signed [PSUM_W-1:0]  psum;
  logic signed [PSUM_W-1:0]  inc_full;
  logic signed [SUM_W-1:0]   fb_ext;
  logic signed [SUM_W-1:0]   delta;
  logic signed [SUM_W-1:0]   addend;
  logic signed [31:0]        acc_cur;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [31:0]        acc_new;
  logic signed [TR_W-1:0]    sel_l;
  logic signed [TR_W-1:0]    sel_r;
  logic signed [PWM_W-1:0]   pwm_l;
  logic signed [PWM_W-1:0]   pwm_r;

  always_comb begin
    exact   = mult_q[33:0];
    ex_hi   = 17'(exact >>> 20);
    tgt_cur = side ? target_rpm_right : target_rpm_left;
    // floor of (exact - target * 2^20) / 2^20, low bits are exact[19:0]
    hi_diff = ex_hi - 17'(tgt_cur);
    ex_rnd  = exact[33] && (exact[19:0] != '0);
    // truncated RPM always fits 14 bits, so no saturation is needed
    tgt_new = 16'(ex_hi + 17'(ex_rnd));
    v_left  = 17'(cmd_linear) - 17'(turn_r);
    v_right = 17'(cmd_linear) + 17'(turn_r);
    err_l   = 17'(target_rpm_left) - 17'(sl_r);
    err_r   = 17'(target_rpm_right) + 17'(sr_r);

    psum     = (PSUM_W'(phi_r) <<< 20) + PSUM_W'(mult_q);
    inc_full = psum >>> INC_SHIFT;

    fb_ext = SUM_W'(exact);
    delta  = (fb_ext <<< FB_SHL) >>> FB_SHR;

    acc_cur = (state == S_FAR || (state == S_ACC && side)) ? drive_right_acc
                                                           : drive_left_acc;
    if (state == S_ACC) begin
      addend = SUM_W'(inc_r);
    end else begin
      addend = cmd_linear[15] ? -delta : delta;
    end
    acc_sum = SUM_W'(acc_cur) + addend;
    acc_new = sat32(acc_sum);

    if (cmd_linear < 0) begin
      sel_l = -il_r;
      sel_r = ir_r;
    end else if (cmd_linear > 0) begin
      sel_l = il_r;
      sel_r = -ir_r;
    end else begin
      sel_l = TR_W'(held_out_left);
      sel_r = TR_W'(held_out_right);
    end
    pwm_l = clamp_pwm(sel_l, regs.pwm_limit);
    pwm_r = clamp_pwm(sel_r, regs.pwm_limit);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TURN: begin
        mul_a = ddw_pkg::MUL_A_W'(cmd_angular);
        mul_b = $signed({1'b0, regs.half_track_width});
      end
      S_EX: begin
        mul_a = ddw_pkg::MUL_A_W'(side ? v_right : v_left);
        mul_b = $signed({1'b0, regs.rpm_per_mps});
      end
      S_HI: begin
        mul_a = ddw_pkg::MUL_A_W'(hi_diff);
        mul_b = $signed({1'b0, regs.gain_p});
      end
      S_LO: begin
        mul_a = $signed({1'b0, lo_r});
        mul_b = $signed({1'b0, regs.gain_p});
      end
      S_FML: begin
        mul_a = ddw_pkg::MUL_A_W'(err_l);
        mul_b = $signed({1'b0, regs.gain_p});
      end
      S_FAL: begin
        mul_a = ddw_pkg::MUL_A_W'(err_r);
        mul_b = $signed({1'b0, regs.gain_p});
      end
      default: ;
    endcase
  end

  // load the output register once the previous result has been taken
  assign emit = (state == S_FOUT) && (!out_valid || result.ready);

  assign item.ready        = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.duty_left  = out_left;
  assign result.duty_right = out_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      side             <= 1'b0;
      out_valid        <= 1'b0;
      cmd_linear       <= '0;
      cmd_angular      <= '0;
      target_rpm_left  <= '0;
      target_rpm_right <= '0;
      drive_left_acc   <= '0;
      drive_right_acc  <= '0;
      held_out_left    <= '0;
      held_out_right   <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            if (item.action == ddw_pkg::ACT_FEEDBACK) begin
              sl_r  <= item.speed_left;
              sr_r  <= item.speed_right;
              state <= S_FML;
            end else begin
              cmd_linear  <= lin_forced;
              cmd_angular <= item.yaw_rate;
              side        <= 1'b0;
              state       <= S_TURN;
            end
          end
        end
        S_TURN:  state <= S_TURNQ;
        S_TURNQ: begin
          turn_r <= 16'(mult_q >>> 16);
          state  <= S_EX;
        end
        S_EX: state <= S_HI;
        S_HI: begin
          lo_r <= exact[19:0];
          if (side) begin
            target_rpm_right <= tgt_new;
          end else begin
            target_rpm_left <= tgt_new;
          end
          state <= S_LO;
        end
        S_LO: begin
          phi_r <= exact;
          state <= S_SUM;
        end
        S_SUM: begin
          inc_r <= inc_full[INC_W-1:0];
          state <= S_ACC;
        end
        S_ACC: begin
          if (side) begin
            drive_right_acc <= acc_new;
            state           <= S_IDLE;
          end else begin
            drive_left_acc <= acc_new;
            side           <= 1'b1;
            state          <= S_EX;
          end
        end
        S_FML: state <= S_FAL;
        S_FAL: begin
          drive_left_acc <= (cmd_linear == 0) ? '0 : acc_new;
          state          <= S_FAR;
        end
        S_FAR: begin
          drive_right_acc <= (cmd_linear == 0) ? '0 : acc_new;
          state           <= S_FTR;
        end
        S_FTR: begin
          il_r  <= trunc_acc(drive_left_acc);
          ir_r  <= trunc_acc(drive_right_acc);
          state <= S_FOUT;
        end
        S_FOUT: begin
          // hold until the previous result has been taken
          if (emit) begin
            out_left  <= pwm_l;
            out_right <= pwm_r;
            if (cmd_linear == 0 && cmd_angular == 0) begin
              held_out_left  <= '0;
              held_out_right <= '0;
            end else begin
              held_out_left  <= pwm_l;
              held_out_right <= pwm_r;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ddw_checker.sv
// ----------------------------------------------------------------------------
// ddw_checker: port-level checks for the wheel PWM regulator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ddw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ddw_pkg::PWM_W-1:0]  duty_left,
  input logic signed [ddw_pkg::PWM_W-1:0]  duty_right
);

  // a stalled result must hold
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty_left) && $stable(duty_right))
    else $error("result changed while stalled");

  // every request drops the request channel ready in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request channel ready straight after a request");

  // a new result only appears at the end of busy work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind diff_drive_wheel_pwm_regulator ddw_checker u_ddw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item.valid),
  .in_ready   (item.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .duty_left  (result.duty_left),
  .duty_right (result.duty_right)
);
